// ===== design/tks_pkg.sv =====
// ----------------------------------------------------------------------------
// tks_pkg: shared types, constants and functions of the Tanimoto top-k scan
// Entry and row types, list size, register indexes and the ranking compare.
// ----------------------------------------------------------------------------
package tks_pkg;

    localparam int TOP_COUNT = 10;
    localparam int IDX_W     = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;

    localparam int WORD_W    = 64;
    localparam int WORDS     = 4;
    localparam int POP_W     = 7;     // popcount of one 64-bit word
    localparam int BITS_W    = 9;
    localparam int UNION_W   = 10;
    localparam int ROW_W     = 32;
    localparam int RANK_W    = 4;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W    = BITS_W + UNION_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUERY_WORD0     = 3'd0,
        CFG_QUERY_WORD1     = 3'd1,
        CFG_QUERY_WORD2     = 3'd2,
        CFG_QUERY_WORD3     = 3'd3,
        CFG_QUERY_BIT_COUNT = 3'd4,
        CFG_QUERY_KEY       = 3'd5
    } cfg_reg_t;

    typedef enum logic {
        ST_SCAN  = 1'b0,
        ST_DRAIN = 1'b1
    } tks_state_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] key;
        logic [ROW_W-1:0]         row;
        logic [BITS_W-1:0]        shared;
        logic [UNION_W-1:0]       uni;
    } entry_t;

    localparam entry_t SENTINEL = '{
        key:    {1'b0, {(WORD_W-1){1'b1}}},
        row:    {ROW_W{1'b1}},
        shared: '0,
        uni:    UNION_W'(1)
    };

    typedef struct packed {
        logic [WORDS-1:0][WORD_W-1:0] words;
        logic signed [WORD_W-1:0]     key;
        logic [BITS_W-1:0]            bit_count;
        logic                         last;
    } row_t;

    typedef struct packed {
        logic   valid;
        logic   skip;
        logic   last;
        entry_t entry;
    } cand_t;

    typedef struct packed {
        logic insert;
        logic shift;
    } cell_ctrl_t;

    function automatic logic [POP_W-1:0] popcount64(input logic [WORD_W-1:0] x);
        logic [POP_W-1:0] n;
        n = '0;
        for (int i = 0; i < WORD_W; i++) begin
            n = n + POP_W'(x[i]);
        end
        return n;
    endfunction

    // True when a ranks strictly above b: larger ratio, then smaller key,
    // then smaller row index.
    function automatic logic ranks_above(input entry_t a, input entry_t b);
        logic [PROD_W-1:0] lhs;
        logic [PROD_W-1:0] rhs;
        logic              res;
        lhs = PROD_W'(a.shared) * PROD_W'(b.uni);
        rhs = PROD_W'(b.shared) * PROD_W'(a.uni);
        if (lhs != rhs) begin
            res = (lhs > rhs);
        end
        else if (a.key != b.key) begin
            res = (a.key < b.key);
        end
        else begin
            res = (a.row < b.row);
        end
        return res;
    endfunction

endpackage

// ===== design/tks_ifs.sv =====
// ----------------------------------------------------------------------------
// tks_ifs: channel interfaces of the Tanimoto top-k scan
// Row input, result output and register write channels, valid/ready each.
// ----------------------------------------------------------------------------
interface tks_row_if;
    logic                 valid;
    logic                 ready;
    logic [63:0]          row_word0;
    logic [63:0]          row_word1;
    logic [63:0]          row_word2;
    logic [63:0]          row_word3;
    logic signed [63:0]   row_key;
    logic [8:0]           row_bit_count;
    logic                 last_row;

    modport source (output valid, row_word0, row_word1, row_word2, row_word3,
                    row_key, row_bit_count, last_row, input ready);
    modport sink   (input valid, row_word0, row_word1, row_word2, row_word3,
                    row_key, row_bit_count, last_row, output ready);
endinterface

interface tks_result_if;
    logic                 valid;
    logic                 ready;
    logic [3:0]           rank;
    logic signed [63:0]   match_key;
    logic [31:0]          match_row;
    logic [8:0]           shared_bits;
    logic [9:0]           union_bits;
    logic                 last_result;

    modport source (output valid, rank, match_key, match_row, shared_bits,
                    union_bits, last_result, input ready);
    modport sink   (input valid, rank, match_key, match_row, shared_bits,
                    union_bits, last_result, output ready);
endinterface

interface tks_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/tks_score.sv =====
// ----------------------------------------------------------------------------
// tks_score: two-stage similarity front end
// Count shared bits per word, then sum them and form the union count.
// ----------------------------------------------------------------------------
module tks_score (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    accept,
    input  tks_pkg::row_t                           row,
    input  logic [tks_pkg::ROW_W-1:0]               row_index,
    input  logic [tks_pkg::WORDS-1:0][tks_pkg::WORD_W-1:0] query_words,
    input  logic [tks_pkg::BITS_W-1:0]              query_bit_count,
    input  logic signed [tks_pkg::WORD_W-1:0]       query_key,
    output tks_pkg::cand_t                          cand
);

    logic                                        s1_valid_reg;
    logic                                        s1_skip_reg;
    logic                                        s1_last_reg;
    logic [tks_pkg::WORDS-1:0][tks_pkg::POP_W-1:0] s1_pop_reg;
    logic signed [tks_pkg::WORD_W-1:0]           s1_key_reg;
    logic [tks_pkg::ROW_W-1:0]                   s1_row_reg;
    logic [tks_pkg::BITS_W-1:0]                  s1_bits_reg;

    tks_pkg::cand_t                              cand_reg;
    tks_pkg::cand_t                              cand_next;

    logic [tks_pkg::BITS_W-1:0]                  shared;
    logic [tks_pkg::UNION_W-1:0]                 sum;

    // Stage 1: per-word popcount of the common bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int w = 0; w < tks_pkg::WORDS; w++)
            begin
                s1_pop_reg[w] <= tks_pkg::popcount64(query_words[w] & row.words[w]);
            end
            s1_skip_reg <= (row.key == query_key);
            s1_last_reg <= row.last;
            s1_key_reg  <= row.key;
            s1_row_reg  <= row_index;
            s1_bits_reg <= row.bit_count;
        end
    end

    // Stage 2: shared total and union, union of zero or less counts as one
    always_comb
    begin
        shared = tks_pkg::BITS_W'(s1_pop_reg[0]) + tks_pkg::BITS_W'(s1_pop_reg[1])
               + tks_pkg::BITS_W'(s1_pop_reg[2]) + tks_pkg::BITS_W'(s1_pop_reg[3]);
        sum    = tks_pkg::UNION_W'(query_bit_count) + tks_pkg::UNION_W'(s1_bits_reg);
        cand_next.valid        = s1_valid_reg;
        cand_next.skip         = s1_skip_reg;
        cand_next.last         = s1_last_reg;
        cand_next.entry.key    = s1_key_reg;
        cand_next.entry.row    = s1_row_reg;
        cand_next.entry.shared = shared;
        cand_next.entry.uni    = (sum > tks_pkg::UNION_W'(shared))
                               ? (sum - tks_pkg::UNION_W'(shared))
                               : tks_pkg::UNION_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_reg <= '0;
        end
        else
        begin
            cand_reg.valid <= cand_next.valid;
            if (s1_valid_reg)
            begin
                cand_reg.skip  <= cand_next.skip;
                cand_reg.last  <= cand_next.last;
                cand_reg.entry <= cand_next.entry;
            end
        end
    end

    assign cand = cand_reg;

endmodule

// ===== design/tks_cell.sv =====
// ----------------------------------------------------------------------------
// tks_cell: one place of the sorted result list
// Compare the broadcast candidate, take it or the upper neighbor's entry on
// insert, take the lower neighbor's entry on drain.
// ----------------------------------------------------------------------------
module tks_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  tks_pkg::cell_ctrl_t ctrl,
    input  tks_pkg::entry_t     cand,
    input  logic                prev_above,
    input  tks_pkg::entry_t     prev_entry,
    input  tks_pkg::entry_t     next_entry,
    output tks_pkg::entry_t     entry,
    output logic                above
);

    tks_pkg::entry_t entry_reg;
    tks_pkg::entry_t entry_next;

    assign above = tks_pkg::ranks_above(cand, entry_reg);

    always_comb
    begin
        priority if (ctrl.shift)
        begin
            entry_next = next_entry;
        end
        else if (ctrl.insert && prev_above)
        begin
            entry_next = prev_entry;
        end
        else if (ctrl.insert && above)
        begin
            entry_next = cand;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= tks_pkg::SENTINEL;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

// ===== design/tanimoto_top_k_scan_unit.sv =====
// ----------------------------------------------------------------------------
// tanimoto_top_k_scan_unit: streaming Tanimoto top-k search
// Score each row against the query and keep the best TOP_COUNT rows in a
// chain of sorting cells; on the last row shift the list out in rank order.
// ----------------------------------------------------------------------------
//
//  channel  | role | handshake   | payload
//  ---------+------+-------------+------------------------------------------
//  rows     | in   | valid/ready | row_word0..3, row_key, row_bit_count,
//           |      |             | last_row
//  results  | out  | valid/ready | rank, match_key, match_row, shared_bits,
//           |      |             | union_bits, last_result
//  cfg      | in   | valid/ready | index, data (always ready)
//
//  One row is taken per cycle while rows.ready is high. A row passes the
//  popcount stage and the union stage before the cell insert.
//  After a last row, rows.ready stays low until the tenth entry has left the
//  cell chain; the drain shifts one entry per cycle and halts while results
//  is stalled. The output register holds one entry; the chain advances
//  when that register is empty or being taken.
//  Reset clears the list to empty slots, the row counter and the query.
// ----------------------------------------------------------------------------
module tanimoto_top_k_scan_unit (
    input  logic          clk,
    input  logic          rst_n,
    tks_row_if.sink       rows,
    tks_result_if.source  results,
    tks_cfg_if.sink       cfg
);

    // Query registers
    logic [tks_pkg::WORDS-1:0][tks_pkg::WORD_W-1:0] query_words_reg;
    logic [tks_pkg::BITS_W-1:0]                   query_bit_count_reg;
    logic signed [tks_pkg::WORD_W-1:0]            query_key_reg;

    // Scan control
    logic [tks_pkg::ROW_W-1:0]  row_count_reg;
    logic                       hold_reg;
    logic                       hold_next;
    tks_pkg::tks_state_t        state_reg;
    tks_pkg::tks_state_t        state_next;
    logic [tks_pkg::IDX_W-1:0]  drain_cnt_reg;
    logic                       drain_done;
    logic                       out_free;
    logic                       accept;

    tks_pkg::row_t              row;
    tks_pkg::cand_t             cand;
    tks_pkg::cell_ctrl_t        ctrl;

    tks_pkg::entry_t            cell_entry [tks_pkg::TOP_COUNT];
    logic                       cell_above [tks_pkg::TOP_COUNT];

    // Output register
    logic                       out_valid_reg;
    tks_pkg::entry_t            out_entry_reg;
    logic [tks_pkg::RANK_W-1:0] out_rank_reg;
    logic                       out_last_reg;

    // ---------------- configuration ----------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_words_reg     <= '0;
            query_bit_count_reg <= '0;
            query_key_reg       <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (tks_pkg::cfg_reg_t'(cfg.index))
                tks_pkg::CFG_QUERY_WORD0:     query_words_reg[0] <= cfg.data;
                tks_pkg::CFG_QUERY_WORD1:     query_words_reg[1] <= cfg.data;
                tks_pkg::CFG_QUERY_WORD2:     query_words_reg[2] <= cfg.data;
                tks_pkg::CFG_QUERY_WORD3:     query_words_reg[3] <= cfg.data;
                tks_pkg::CFG_QUERY_BIT_COUNT:
                    query_bit_count_reg <= cfg.data[tks_pkg::BITS_W-1:0];
                tks_pkg::CFG_QUERY_KEY:       query_key_reg <= $signed(cfg.data);
                default:                      ; // drop writes to unused indexes
            endcase
        end
    end

    // ---------------- input side ----------------
    // Hold input from the last row until its list has been shifted out.
    assign rows.ready = !hold_reg;
    assign accept     = rows.valid && rows.ready;

    always_comb
    begin
        row.words[0]  = rows.row_word0;
        row.words[1]  = rows.row_word1;
        row.words[2]  = rows.row_word2;
        row.words[3]  = rows.row_word3;
        row.key       = rows.row_key;
        row.bit_count = rows.row_bit_count;
        row.last      = rows.last_row;
    end

    // Number rows; restart at zero after a last row, skipped rows count too.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= '0;
        end
        else if (accept)
        begin
            row_count_reg <= rows.last_row ? '0 : row_count_reg + 1'b1;
        end
    end

    tks_score u_score (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .row             (row),
        .row_index       (row_count_reg),
        .query_words     (query_words_reg),
        .query_bit_count (query_bit_count_reg),
        .query_key       (query_key_reg),
        .cand            (cand)
    );

    // ---------------- control ----------------
    assign out_free   = !out_valid_reg || results.ready;
    assign drain_done = ctrl.shift && (drain_cnt_reg == tks_pkg::IDX_W'(tks_pkg::TOP_COUNT - 1));

    // Next state: start draining once the last row has been inserted.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tks_pkg::ST_SCAN:
            begin
                if (cand.valid && cand.last)
                begin
                    state_next = tks_pkg::ST_DRAIN;
                end
            end
            tks_pkg::ST_DRAIN:
            begin
                if (drain_done)
                begin
                    state_next = tks_pkg::ST_SCAN;
                end
            end
            default: state_next = tks_pkg::ST_SCAN;
        endcase
    end

    // Outputs: insert non-skipped rows, advance the chain while draining.
    always_comb
    begin
        ctrl.insert = 1'b0;
        ctrl.shift  = 1'b0;
        unique case (state_reg)
            tks_pkg::ST_SCAN:  ctrl.insert = cand.valid && !cand.skip;
            tks_pkg::ST_DRAIN: ctrl.shift  = out_free;
            default:           ;
        endcase
    end

    always_comb
    begin
        hold_next = hold_reg;
        priority if (accept && rows.last_row)
        begin
            hold_next = 1'b1;
        end
        else if (drain_done)
        begin
            hold_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tks_pkg::ST_SCAN;
            hold_reg      <= 1'b0;
            drain_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            hold_reg  <= hold_next;
            if (drain_done)
            begin
                drain_cnt_reg <= '0;
            end
            else if (ctrl.shift)
            begin
                drain_cnt_reg <= drain_cnt_reg + 1'b1;
            end
        end
    end

    // ---------------- cell chain ----------------
    // Cell 0 holds the best entry. Draining pulls empty slots in at the far
    // end, so the list is cleared as it is shifted out.
    for (genvar i = 0; i < tks_pkg::TOP_COUNT; i++)
    begin : g_cell
        logic            prev_above;
        tks_pkg::entry_t prev_entry;
        tks_pkg::entry_t next_entry;

        if (i == 0)
        begin : g_head
            assign prev_above = 1'b0;
            assign prev_entry = cell_entry[0];
        end
        else
        begin : g_body
            assign prev_above = cell_above[i-1];
            assign prev_entry = cell_entry[i-1];
        end

        if (i == tks_pkg::TOP_COUNT - 1)
        begin : g_tail
            assign next_entry = tks_pkg::SENTINEL;
        end
        else
        begin : g_link
            assign next_entry = cell_entry[i+1];
        end

        tks_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .cand       (cand.entry),
            .prev_above (prev_above),
            .prev_entry (prev_entry),
            .next_entry (next_entry),
            .entry      (cell_entry[i]),
            .above      (cell_above[i])
        );
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.shift)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            out_entry_reg <= cell_entry[0];
            out_rank_reg  <= tks_pkg::RANK_W'(drain_cnt_reg);
            out_last_reg  <= drain_done;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.rank        = out_rank_reg;
    assign results.match_key   = out_entry_reg.key;
    assign results.match_row   = out_entry_reg.row;
    assign results.shared_bits = out_entry_reg.shared;
    assign results.union_bits  = out_entry_reg.uni;
    assign results.last_result = out_last_reg;

    // ---------------- assertions ----------------
    a_no_input_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tks_pkg::ST_DRAIN |-> !rows.ready)
        else $error("row accepted while list is draining");

    a_last_rank: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.last_result
            |-> results.rank == tks_pkg::RANK_W'(tks_pkg::TOP_COUNT - 1))
        else $error("final result carries wrong rank");

    a_drain_ends: assert property (@(posedge clk) disable iff (!rst_n)
        drain_done |=> state_reg == tks_pkg::ST_SCAN && rows.ready)
        else $error("scan did not resume after drain");

    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        !tks_pkg::ranks_above(cell_entry[1], cell_entry[0]))
        else $error("cell chain out of order");

endmodule
